/* hw/rtl/serial_frame_receiver_assert.svh */
// Assertion macros used by the checker of the serial frame receiver.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("serial_frame_receiver: sequential check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("serial_frame_receiver: same-cycle check failed");

`endif

/* hw/rtl/sfr_pkg.sv */
package sfr_pkg;

	localparam logic [7:0] SYNC_BYTE  = 8'hAA;
	localparam logic [7:0] FUNC_LIMIT = 8'hFF;

	localparam logic [5:0] MAX_LEN_RESET = 6'd32;
	localparam logic [7:0] WATCHED_RESET = 8'hF1;

	// Register index is taken from paddr[2].
	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic REG_WATCHED = 1'b1;

	typedef enum logic [5:0] {
		PH_SYNC1   = 6'b000001,
		PH_SYNC2   = 6'b000010,
		PH_FUNC    = 6'b000100,
		PH_LEN     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_TRAIL   = 6'b100000
	} sfr_phase_t;

	typedef struct packed {
		logic [5:0] max_len;
		logic [7:0] watched_func;
	} sfr_cfg_t;

	typedef struct packed {
		logic [7:0] func_code;
		logic [5:0] payload_len;
		logic [7:0] value_a;
		logic [7:0] value_b;
		logic       values_updated;
	} sfr_result_t;

endpackage

/* hw/rtl/sfr_regs.sv */
module sfr_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output sfr_pkg::sfr_cfg_t cfg
);
	import sfr_pkg::*;

	logic       wr_en;
	logic [5:0] max_len_q;
	logic [7:0] watched_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
			watched_q <= WATCHED_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MAX_LEN: max_len_q <= pwdata[5:0];
				REG_WATCHED: watched_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_LEN: prdata = {26'd0, max_len_q};
			REG_WATCHED: prdata = {24'd0, watched_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg.max_len      = max_len_q;
	assign cfg.watched_func = watched_q;

endmodule

/* hw/rtl/sfr_parser.sv */
module sfr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	input  sfr_pkg::sfr_cfg_t    cfg,
	output logic                 res_valid,
	output sfr_pkg::sfr_result_t res
);
	import sfr_pkg::*;

	sfr_phase_t phase_q, phase_d;
	logic [5:0] remaining_q, remaining_d;
	logic [5:0] offset_q, offset_d;
	logic [7:0] func_q, func_d;
	logic [5:0] len_q, len_d;
	logic [7:0] win_q [4];
	logic [7:0] win_d [4];
	logic [7:0] held_a_q, held_a_d;
	logic [7:0] held_b_q, held_b_d;
	logic       updated;

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		offset_d    = offset_q;
		func_d      = func_q;
		len_d       = len_q;
		win_d       = win_q;
		held_a_d    = held_a_q;
		held_b_d    = held_b_q;
		updated     = 1'b0;
		res_valid   = 1'b0;
		case (phase_q)
			PH_SYNC1: begin
				phase_d = (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
			end
			PH_SYNC2: begin
				phase_d = (rx_byte == SYNC_BYTE) ? PH_FUNC : PH_SYNC1;
			end
			PH_FUNC: begin
				if (rx_byte < FUNC_LIMIT) begin
					func_d  = rx_byte;
					phase_d = PH_LEN;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_LEN: begin
				if (rx_byte <= {2'b00, cfg.max_len}) begin
					len_d       = rx_byte[5:0];
					remaining_d = rx_byte[5:0];
					offset_d    = 6'd0;
					phase_d     = PH_PAYLOAD;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_PAYLOAD: begin
				// A zero length lands here with nothing left, so this byte aborts the frame.
				if (remaining_q != 6'd0) begin
					remaining_d = remaining_q - 6'd1;
					if (offset_q < 6'd4) begin
						win_d[offset_q[1:0]] = rx_byte;
					end
					offset_d = offset_q + 6'd1;
					if (remaining_q == 6'd1) begin
						phase_d = PH_TRAIL;
					end
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_TRAIL: begin
				phase_d   = PH_SYNC1;
				res_valid = 1'b1;
				// The sum byte may overwrite a window byte before A and B are taken.
				if (offset_q < 6'd4) begin
					win_d[offset_q[1:0]] = rx_byte;
				end
				if (func_q == cfg.watched_func) begin
					held_a_d = win_d[1];
					held_b_d = win_d[3];
					updated  = 1'b1;
				end
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
	end

	assign res.func_code      = func_q;
	assign res.payload_len    = len_q;
	assign res.value_a        = held_a_d;
	assign res.value_b        = held_b_d;
	assign res.values_updated = updated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC1;
			remaining_q <= 6'd0;
			offset_q    <= 6'd0;
			func_q      <= 8'd0;
			len_q       <= 6'd0;
			win_q       <= '{default: 8'd0};
			held_a_q    <= 8'd0;
			held_b_q    <= 8'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			offset_q    <= offset_d;
			func_q      <= func_d;
			len_q       <= len_d;
			win_q       <= win_d;
			held_a_q    <= held_a_d;
			held_b_q    <= held_b_d;
		end
	end

endmodule

/* hw/rtl/serial_frame_receiver.sv */
// Serial frame receiver: takes one received byte per item on the s_ side and
// hunts for frames of sync 0xAA, sync 0xAA, function byte (below 0xFF), length
// byte (at most max_len), that many payload bytes and one sum byte, which is
// not checked. For each completed frame one item leaves on the m_ side with
// the function code, the length, the two held values and a flag that is set
// when the function matched watched_func and the values were reloaded from
// frame positions 5 and 7. The block takes one byte every clock cycle unless a
// result waits on a stalled output; the frame state machine updates from an
// input register, and a result is then held in an output register. A stalled
// result item only holds up the input once a second result arrives.
module serial_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] func_code, [13:8] payload_len,
	                              // [21:14] value_a, [29:22] value_b, [31:30] zero
	output logic        m_tuser,  // [0] values_updated
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sfr_pkg::*;

	sfr_cfg_t    cfg;
	sfr_result_t res;
	sfr_result_t out_q;
	logic        res_valid;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic        out_free;
	logic        advance;

	sfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	assign out_free = !out_valid_q || m_tready;
	// A byte that produces no result never waits on the output side.
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.value_b, out_q.value_a, out_q.payload_len,
	                   out_q.func_code};
	assign m_tuser  = out_q.values_updated;

endmodule

/* hw/rtl/sfr_checker.sv */
`include "serial_frame_receiver_assert.svh"

module sfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled result item stays offered.
	`SFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	// Only frames with a nonzero length ever complete.
	`SFR_ASSERT_NOW(a_len_nonzero, m_tvalid, m_tdata[13:8] != 6'd0)
	// The function byte 0xFF always aborts a frame.
	`SFR_ASSERT_NOW(a_func_legal, m_tvalid, m_tdata[7:0] != 8'hFF)
	// The padding above the packed fields stays clear.
	`SFR_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[31:30] == 2'b00)

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);
